// ----- src/ntc_voltage_to_temperature_core_defines.svh -----
// Assertion macros used by the thermistor conversion top level.
`ifndef NTC_VOLTAGE_TO_TEMPERATURE_CORE_DEFINES_SVH
`define NTC_VOLTAGE_TO_TEMPERATURE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define NTCVT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define NTCVT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/ntcvt_pkg.sv -----
// Types, constants and lookup tables for the thermistor conversion pipeline.
`default_nettype none
package ntcvt_pkg;

  localparam int ROM_POINTS  = 18;
  localparam int SEG_W       = 5;
  localparam int VOLT_W      = 16;
  localparam int TEMP_W      = 15;
  localparam int DT_W        = 12;
  localparam int DX_W        = 12;
  localparam int NUM_W       = DT_W + DX_W + 1;
  localparam int DBL_W       = 13;
  localparam int RECIP_W     = 23;
  localparam int X_W         = 23;
  localparam int Q_W         = 12;
  localparam int RECIP_SHIFT = 32;
  localparam int PROD_W      = X_W + RECIP_W;
  localparam int QD_W        = Q_W + DBL_W;
  localparam int REM_W       = X_W + 3;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_THRESHOLD  = 2'd1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_OPEN  = 2'd2;

  localparam logic [VOLT_W-1:0] SHORT_THRESHOLD_RST = 16'd800;
  localparam logic [VOLT_W-1:0] OPEN_THRESHOLD_RST  = 16'd24600;

  typedef logic [VOLT_W-1:0]        volt_t;
  typedef logic signed [TEMP_W-1:0] temp_t;

  // Breakpoint voltages, ascending, 100 uV units.
  localparam volt_t VOLT_ROM [ROM_POINTS] = '{
    16'd937,   16'd1380,  16'd1807,  16'd2459,  16'd3225,  16'd4281,
    16'd5659,  16'd7415,  16'd9621,  16'd12169, 16'd13520, 16'd14900,
    16'd17566, 16'd19899, 16'd21784, 16'd23124, 16'd24009, 16'd24550
  };

  // Breakpoint temperatures, 0.01 degC.
  localparam temp_t TEMP_ROM [ROM_POINTS] = '{
    15'sd12500, 15'sd11000, 15'sd10000, 15'sd9000,  15'sd8000,  15'sd7000,
    15'sd6000,  15'sd5000,  15'sd4000,  15'sd3000,  15'sd2500,  15'sd2000,
    15'sd1000,  15'sd0,     -15'sd1000, -15'sd2000, -15'sd3000, -15'sd4000
  };

  // floor(2^32 / (2 * segment width)) for each segment.
  localparam logic [RECIP_W-1:0] RECIP_ROM [ROM_POINTS-1] = '{
    23'd4847592, 23'd5029235, 23'd3293686, 23'd2803503, 23'd2033601,
    23'd1558406, 23'd1222940, 23'd973474,  23'd842811,  23'd1589551,
    23'd1556147, 23'd805507,  23'd920481,  23'd1139248, 23'd1602599,
    23'd2426535, 23'd3969470
  };

  // Segment operands handed from the locate stages to the scaling stages.
  typedef struct packed {
    logic                    vld;
    logic [1:0]              status;
    temp_t                   t0;
    logic signed [DT_W-1:0]  dt;
    logic [DX_W-1:0]         dx;
    logic [DBL_W-1:0]        dbl;
    logic [RECIP_W-1:0]      recip;
  } seg_t;

  // Rounded-division operands handed to the divide stages.
  typedef struct packed {
    logic               vld;
    logic [1:0]         status;
    temp_t              t0;
    logic               neg;
    logic [X_W-1:0]     x;
    logic [DBL_W-1:0]   dbl;
    logic [RECIP_W-1:0] recip;
  } quo_t;

endpackage
`default_nettype wire

// ----- src/ntcvt_locate.sv -----
// Input register, threshold checks, segment search and table lookup (three stages).
`default_nettype none
module ntcvt_locate
  import ntcvt_pkg::*;
#(
  parameter int TABLE_POINTS = 18
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_vld,
  input  wire volt_t in_volt,
  input  wire volt_t short_thr,
  input  wire volt_t open_thr,
  output seg_t       seg_o
);

  localparam int USED = (TABLE_POINTS < ROM_POINTS) ?
                        ((TABLE_POINTS < 2) ? 2 : TABLE_POINTS) : ROM_POINTS;
  localparam int LAST = USED - 1;

  // stage A
  logic  a_vld_r;
  volt_t a_volt_r;

  // stage B
  logic             b_vld_r;
  logic [1:0]       b_status_r, b_status_nxt;
  volt_t            b_volt_r;
  logic [SEG_W-1:0] b_seg_r, b_seg_nxt;
  logic             b_lo_r, b_hi_r;

  // stage C
  seg_t c_r, c_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
    end
  end

  always_comb begin
    if (a_volt_r < short_thr) begin
      b_status_nxt = ST_SHORT;
    end else if (a_volt_r > open_thr) begin
      b_status_nxt = ST_OPEN;
    end else begin
      b_status_nxt = ST_OK;
    end
    // Breakpoints ascend: the last one at or below the sample wins.
    b_seg_nxt = '0;
    for (int k = 1; k < ROM_POINTS - 1; k++) begin
      if (k < LAST && a_volt_r >= VOLT_ROM[k]) begin
        b_seg_nxt = SEG_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    a_volt_r   <= in_volt;
    b_status_r <= b_status_nxt;
    b_volt_r   <= a_volt_r;
    b_seg_r    <= b_seg_nxt;
    b_lo_r     <= (a_volt_r <= VOLT_ROM[0]);
    b_hi_r     <= (a_volt_r >= VOLT_ROM[LAST]);
  end

  logic [SEG_W-1:0] seg_hi;
  volt_t            dv;
  temp_t            dt_full;
  volt_t            dx_full;

  always_comb begin
    seg_hi  = b_seg_r + SEG_W'(1);
    dv      = VOLT_ROM[seg_hi] - VOLT_ROM[b_seg_r];
    dt_full = TEMP_ROM[seg_hi] - TEMP_ROM[b_seg_r];
    dx_full = b_volt_r - VOLT_ROM[b_seg_r];
    c_nxt        = '0;
    c_nxt.vld    = b_vld_r;
    c_nxt.status = b_status_r;
    c_nxt.t0     = b_hi_r ? TEMP_ROM[LAST] : TEMP_ROM[b_seg_r];
    // Beyond either end: zero slope, hold the end temperature.
    c_nxt.dt     = (b_lo_r || b_hi_r) ? '0 : DT_W'(dt_full);
    c_nxt.dx     = (b_lo_r || b_hi_r) ? '0 : DX_W'(dx_full);
    c_nxt.dbl    = {dv[DBL_W-2:0], 1'b0};
    c_nxt.recip  = RECIP_ROM[b_seg_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r <= '0;
    end else begin
      c_r <= c_nxt;
    end
  end

  assign seg_o = c_r;

endmodule
`default_nettype wire

// ----- src/ntcvt_scale.sv -----
// Slope product and rounding numerator (two stages).
`default_nettype none
module ntcvt_scale
  import ntcvt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire seg_t seg_i,
  output quo_t      quo_o
);

  // stage D
  logic                    d_vld_r;
  logic [1:0]              d_status_r;
  temp_t                   d_t0_r;
  logic signed [NUM_W-1:0] d_num_r, d_num_nxt;
  logic [DBL_W-1:0]        d_dbl_r;
  logic [RECIP_W-1:0]      d_recip_r;

  // stage E
  quo_t e_r, e_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else begin
      d_vld_r <= seg_i.vld;
    end
  end

  assign d_num_nxt = NUM_W'(seg_i.dt * $signed({1'b0, seg_i.dx}));

  always_ff @(posedge clk) begin
    d_status_r <= seg_i.status;
    d_t0_r     <= seg_i.t0;
    d_num_r    <= d_num_nxt;
    d_dbl_r    <= seg_i.dbl;
    d_recip_r  <= seg_i.recip;
  end

  logic [NUM_W-1:0] mag;

  always_comb begin
    mag          = d_num_r[NUM_W-1] ? NUM_W'(-d_num_r) : NUM_W'(d_num_r);
    e_nxt        = '0;
    e_nxt.vld    = d_vld_r;
    e_nxt.status = d_status_r;
    e_nxt.t0     = d_t0_r;
    e_nxt.neg    = d_num_r[NUM_W-1];
    // Round half away from zero: (2|n| + w) / (2w).
    e_nxt.x      = X_W'({mag, 1'b0}) + X_W'(d_dbl_r >> 1);
    e_nxt.dbl    = d_dbl_r;
    e_nxt.recip  = d_recip_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_r <= '0;
    end else begin
      e_r <= e_nxt;
    end
  end

  assign quo_o = e_r;

endmodule
`default_nettype wire

// ----- src/ntcvt_divide.sv -----
// Reciprocal divide, remainder correction and result register (three stages).
`default_nettype none
module ntcvt_divide
  import ntcvt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire quo_t  quo_i,
  output logic       out_valid,
  output temp_t      out_temp,
  output logic [1:0] out_status
);

  // stage F
  logic               f_vld_r;
  logic [1:0]         f_status_r;
  temp_t              f_t0_r;
  logic               f_neg_r;
  logic [X_W-1:0]     f_x_r;
  logic [DBL_W-1:0]   f_dbl_r;
  logic [Q_W-1:0]     f_q0_r;
  logic [PROD_W-1:0]  prod;

  // stage G
  logic               g_vld_r;
  logic [1:0]         g_status_r;
  temp_t              g_t0_r;
  logic               g_neg_r;
  logic [X_W-1:0]     g_x_r;
  logic [DBL_W-1:0]   g_dbl_r;
  logic [Q_W-1:0]     g_q0_r;
  logic [QD_W-1:0]    g_qd_r;

  // stage H
  logic               h_vld_r;
  temp_t              h_temp_r, h_temp_nxt;
  logic [1:0]         h_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
      g_vld_r <= 1'b0;
      h_vld_r <= 1'b0;
    end else begin
      f_vld_r <= quo_i.vld;
      g_vld_r <= f_vld_r;
      h_vld_r <= g_vld_r;
    end
  end

  assign prod = PROD_W'(quo_i.x * quo_i.recip);

  always_ff @(posedge clk) begin
    f_status_r <= quo_i.status;
    f_t0_r     <= quo_i.t0;
    f_neg_r    <= quo_i.neg;
    f_x_r      <= quo_i.x;
    f_dbl_r    <= quo_i.dbl;
    f_q0_r     <= prod[RECIP_SHIFT +: Q_W];
    g_status_r <= f_status_r;
    g_t0_r     <= f_t0_r;
    g_neg_r    <= f_neg_r;
    g_x_r      <= f_x_r;
    g_dbl_r    <= f_dbl_r;
    g_q0_r     <= f_q0_r;
    g_qd_r     <= QD_W'(f_q0_r * f_dbl_r);
  end

  logic signed [REM_W-1:0] rem;
  logic [Q_W-1:0]          q;
  temp_t                   q_ext;

  always_comb begin
    rem = $signed(REM_W'(g_x_r)) - $signed(REM_W'(g_qd_r));
    // Estimate may sit one off the true quotient; nudge it back.
    if (rem < 0) begin
      q = g_q0_r - Q_W'(1);
    end else if (rem >= $signed(REM_W'(g_dbl_r))) begin
      q = g_q0_r + Q_W'(1);
    end else begin
      q = g_q0_r;
    end
    q_ext = $signed(TEMP_W'(q));
    if (g_status_r != ST_OK) begin
      h_temp_nxt = '0;
    end else if (g_neg_r) begin
      h_temp_nxt = g_t0_r - q_ext;
    end else begin
      h_temp_nxt = g_t0_r + q_ext;
    end
  end

  always_ff @(posedge clk) begin
    h_temp_r   <= h_temp_nxt;
    h_status_r <= g_status_r;
  end

  assign out_valid  = h_vld_r;
  assign out_temp   = h_temp_r;
  assign out_status = h_status_r;

endmodule
`default_nettype wire

// ----- src/ntc_voltage_to_temperature_core.sv -----
// Each accepted start passes through stages A to H; out_valid is the stage H valid register.
// Throughput: one sample per cycle; busy stays low, eight register stages in flight.
// The stages run in order: lookup, slope multiply, reciprocal multiply, fix-up.
// Reset (rst_n low, synchronous) drops all transactions in flight and reloads
// the short and open thresholds to 800 and 24600; results cannot be stalled.
`default_nettype none
`include "ntc_voltage_to_temperature_core_defines.svh"
module ntc_voltage_to_temperature_core
  import ntcvt_pkg::*;
#(
  parameter int TABLE_POINTS = 18
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [VOLT_W-1:0]    in_sample_voltage,
  output logic                      out_valid,
  output logic signed [TEMP_W-1:0]  out_temperature_centi,
  output logic [1:0]                out_status_code,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [VOLT_W-1:0]    cfg_data
);

  volt_t short_thr_r, open_thr_r;
  seg_t  seg;
  quo_t  quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_thr_r <= SHORT_THRESHOLD_RST;
      open_thr_r  <= OPEN_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHORT_THRESHOLD: short_thr_r <= cfg_data;
        REG_OPEN_THRESHOLD:  open_thr_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  ntcvt_locate #(
    .TABLE_POINTS(TABLE_POINTS)
  ) u_locate (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (start && !busy),
    .in_volt   (in_sample_voltage),
    .short_thr (short_thr_r),
    .open_thr  (open_thr_r),
    .seg_o     (seg)
  );

  ntcvt_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .seg_i (seg),
    .quo_o (quo)
  );

  ntcvt_divide u_divide (
    .clk        (clk),
    .rst_n      (rst_n),
    .quo_i      (quo),
    .out_valid  (out_valid),
    .out_temp   (out_temperature_centi),
    .out_status (out_status_code)
  );

  logic res_ok;
  logic res_fault;
  logic temp_in_span;

  assign res_ok       = out_valid && out_status_code == ST_OK;
  assign res_fault    = out_valid && out_status_code != ST_OK;
  assign temp_in_span = out_temperature_centi >= -15'sd4000 &&
                        out_temperature_centi <= 15'sd12500;

  `NTCVT_ASSERT_IMPL(a_status_legal, out_valid, out_status_code <= ST_OPEN, "illegal status code")
  `NTCVT_ASSERT_IMPL(a_fault_zero, res_fault, out_temperature_centi == '0, "fault with temperature")
  `NTCVT_ASSERT_IMPL(a_temp_range, res_ok, temp_in_span, "temperature outside table span")
  `NTCVT_ASSERT_IMPL(a_quo_flow, 1'b1, out_valid == $past(quo.vld, 3), "result strobe out of step")

endmodule
`default_nettype wire
